>>> hdl/euler_xyz_to_rotation_matrix_defines.svh
// Assertion macros used by the checker file.
`ifndef EULER_XYZ_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_XYZ_TO_ROTATION_MATRIX_DEFINES_SVH

// Check a property that is ignored while reset is asserted.
`define EXR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property that also covers the reset cycles.
`define EXR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> hdl/exr_pkg.sv
// Types, constants and the arctangent table for the Euler angle to rotation matrix block.
`default_nettype none
package exr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int STAGE_CNT     = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int SHIFT_W       = $clog2(ATAN_LEN);

    localparam int ANGLE_W     = 16;
    localparam int TRANS_W     = 32;
    localparam int ENTRY_W     = 16;
    localparam int ANGLE_SHIFT = 17;
    localparam int Z_W         = ANGLE_W + ANGLE_SHIFT;
    localparam int XY_W        = 34;
    localparam int TRIG_W      = 32;
    localparam int Q_FRAC      = 30;
    localparam int OUT_SHIFT   = 16;

    localparam logic signed [ANGLE_W-1:0] ANG_LIMIT   = 16'sd25736;
    localparam logic signed [Z_W-1:0]     HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [Z_W-1:0]     PI_Q30      = 33'sd3373259426;
    localparam logic signed [XY_W-1:0]    GAIN_Q30    = 34'sd652032874;
    localparam logic signed [ENTRY_W-1:0] ONE_Q14     = 16'sd16384;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_x;
        logic signed [ANGLE_W-1:0] angle_y;
        logic signed [ANGLE_W-1:0] angle_z;
        logic signed [TRANS_W-1:0] trans_x;
        logic signed [TRANS_W-1:0] trans_y;
        logic signed [TRANS_W-1:0] trans_z;
    } exr_in_t;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] r00;
        logic signed [ENTRY_W-1:0] r01;
        logic signed [ENTRY_W-1:0] r02;
        logic signed [ENTRY_W-1:0] r10;
        logic signed [ENTRY_W-1:0] r11;
        logic signed [ENTRY_W-1:0] r12;
        logic signed [ENTRY_W-1:0] r20;
        logic signed [ENTRY_W-1:0] r21;
        logic signed [ENTRY_W-1:0] r22;
        logic signed [TRANS_W-1:0] pass_trans_x;
        logic signed [TRANS_W-1:0] pass_trans_y;
        logic signed [TRANS_W-1:0] pass_trans_z;
    } exr_out_t;

    typedef struct packed {
        logic signed [TRANS_W-1:0] x;
        logic signed [TRANS_W-1:0] y;
        logic signed [TRANS_W-1:0] z;
    } exr_trans_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
    } exr_lane_t;

    // lane 0 rotates about X, lane 1 about Y, lane 2 about Z
    typedef struct packed {
        exr_lane_t [2:0] lane;
        exr_trans_t      trans;
    } exr_cordic_t;

    function automatic logic signed [Z_W-1:0] exr_atan(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            0:       v = 33'sh03243F6A8;
            1:       v = 33'sh01DAC6705;
            2:       v = 33'sh00FADBAFC;
            3:       v = 33'sh007F56EA6;
            4:       v = 33'sh003FEAB76;
            5:       v = 33'sh001FFD55B;
            6:       v = 33'sh000FFFAAA;
            7:       v = 33'sh0007FFF55;
            8:       v = 33'sh0003FFFEA;
            9:       v = 33'sh0001FFFFD;
            10:      v = 33'sh0000FFFFF;
            11:      v = 33'sh00007FFFF;
            12:      v = 33'sh00003FFFF;
            13:      v = 33'sh00001FFFF;
            14:      v = 33'sh00000FFFF;
            15:      v = 33'sh000007FFF;
            16:      v = 33'sh000003FFF;
            17:      v = 33'sh000001FFF;
            18:      v = 33'sh000000FFF;
            19:      v = 33'sh0000007FF;
            20:      v = 33'sh0000003FF;
            21:      v = 33'sh0000001FF;
            22:      v = 33'sh0000000FF;
            23:      v = 33'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hdl/exr_fold.sv
// Input stage: clamps each angle, scales it to Q30 and folds it into -pi/2..pi/2.
`default_nettype none
module exr_fold (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire exr_pkg::exr_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output exr_pkg::exr_cordic_t  out_data
);
    import exr_pkg::*;

    logic        valid_reg;
    exr_cordic_t data_reg;
    exr_cordic_t data_next;

    function automatic exr_lane_t fold_lane(input logic signed [ANGLE_W-1:0] angle);
        logic signed [ANGLE_W-1:0] a;
        exr_lane_t                 ln;
        a = angle;
        if (a > ANG_LIMIT) begin
            a = ANG_LIMIT;
        end else if (a < -ANG_LIMIT) begin
            a = -ANG_LIMIT;
        end
        ln.z   = Z_W'(a) <<< ANGLE_SHIFT;
        ln.neg = 1'b0;
        if (ln.z > HALF_PI_Q30) begin
            ln.z   = ln.z - PI_Q30;
            ln.neg = 1'b1;
        end else if (ln.z < -HALF_PI_Q30) begin
            ln.z   = ln.z + PI_Q30;
            ln.neg = 1'b1;
        end
        ln.x = GAIN_Q30;
        ln.y = '0;
        return ln;
    endfunction

    always_comb begin
        data_next.lane[0] = fold_lane(in_data.angle_x);
        data_next.lane[1] = fold_lane(in_data.angle_y);
        data_next.lane[2] = fold_lane(in_data.angle_z);
        data_next.trans.x = in_data.trans_x;
        data_next.trans.y = in_data.trans_y;
        data_next.trans.z = in_data.trans_z;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> hdl/exr_cell.sv
// One CORDIC rotation step for the three angle lanes, with its own stage register.
`default_nettype none
module exr_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [exr_pkg::SHIFT_W-1:0] shift,
    input  wire logic signed [exr_pkg::Z_W-1:0] atan,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire exr_pkg::exr_cordic_t        in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output exr_pkg::exr_cordic_t             out_data
);
    import exr_pkg::*;

    logic        valid_reg;
    exr_cordic_t data_reg;
    exr_cordic_t data_next;

    function automatic exr_lane_t step_lane(input exr_lane_t ln,
                                            input logic [SHIFT_W-1:0] sh,
                                            input logic signed [Z_W-1:0] at);
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        exr_lane_t              r;
        dx    = ln.y >>> sh;
        dy    = ln.x >>> sh;
        r.neg = ln.neg;
        if (!ln.z[Z_W-1]) begin
            r.x = ln.x - dx;
            r.y = ln.y + dy;
            r.z = ln.z - at;
        end else begin
            r.x = ln.x + dx;
            r.y = ln.y - dy;
            r.z = ln.z + at;
        end
        return r;
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            data_next.lane[k] = step_lane(in_data.lane[k], shift, atan);
        end
        data_next.trans = in_data.trans;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> hdl/exr_matrix.sv
// Product stages: forms the nine rotation matrix entries and holds the output beat.
`default_nettype none
module exr_matrix (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire exr_pkg::exr_cordic_t in_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output exr_pkg::exr_out_t         m_data
);
    import exr_pkg::*;

    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        trig_t      cycz, cysz, cxsz, cxcz, sxcy, sxsz, sxcz, cxcy;
        trig_t      sxsy, cxsy, sy, sz, cz;
        exr_trans_t trans;
    } prod_t;

    typedef struct packed {
        trig_t      sxsycz, sxsysz, cxsycz, cxsysz;
        trig_t      cycz, cysz, cxsz, cxcz, sxcy, sxsz, sxcz, cxcy, sy;
        exr_trans_t trans;
    } triple_t;

    localparam logic signed [2*TRIG_W-1:0] ROUND_PROD = (2*TRIG_W)'(1) <<< (Q_FRAC - 1);
    localparam logic signed [TRIG_W:0]     ROUND_OUT  = (TRIG_W+1)'(1) <<< (OUT_SHIFT - 1);

    function automatic trig_t mul30(input trig_t a, input trig_t b);
        logic signed [2*TRIG_W-1:0] p;
        p = a * b;
        p = p + ROUND_PROD;
        return p[TRIG_W+Q_FRAC-1:Q_FRAC];
    endfunction

    function automatic logic signed [ENTRY_W-1:0] to_q14(input logic signed [TRIG_W:0] v);
        logic signed [TRIG_W:0] r;
        r = (v + ROUND_OUT) >>> OUT_SHIFT;
        if (r > (TRIG_W+1)'(ONE_Q14)) begin
            return ONE_Q14;
        end else if (r < -(TRIG_W+1)'(ONE_Q14)) begin
            return -ONE_Q14;
        end
        return r[ENTRY_W-1:0];
    endfunction

    function automatic logic signed [TRIG_W:0] ext(input trig_t v);
        return (TRIG_W+1)'(v);
    endfunction

    trig_t    sn [3];
    trig_t    cs [3];
    logic     a_valid_reg;
    logic     b_valid_reg;
    logic     o_valid_reg;
    prod_t    a_reg;
    prod_t    a_next;
    triple_t  b_reg;
    triple_t  b_next;
    exr_out_t o_reg;
    exr_out_t o_next;
    logic     a_ready;
    logic     b_ready;
    logic     o_ready;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sn[k] = in_data.lane[k].neg ? TRIG_W'(-in_data.lane[k].y) : TRIG_W'(in_data.lane[k].y);
            cs[k] = in_data.lane[k].neg ? TRIG_W'(-in_data.lane[k].x) : TRIG_W'(in_data.lane[k].x);
        end
        a_next.cycz  = mul30(cs[1], cs[2]);
        a_next.cysz  = mul30(cs[1], sn[2]);
        a_next.cxsz  = mul30(cs[0], sn[2]);
        a_next.cxcz  = mul30(cs[0], cs[2]);
        a_next.sxcy  = mul30(sn[0], cs[1]);
        a_next.sxsz  = mul30(sn[0], sn[2]);
        a_next.sxcz  = mul30(sn[0], cs[2]);
        a_next.cxcy  = mul30(cs[0], cs[1]);
        a_next.sxsy  = mul30(sn[0], sn[1]);
        a_next.cxsy  = mul30(cs[0], sn[1]);
        a_next.sy    = sn[1];
        a_next.sz    = sn[2];
        a_next.cz    = cs[2];
        a_next.trans = in_data.trans;
    end

    always_comb begin
        b_next.sxsycz = mul30(a_reg.sxsy, a_reg.cz);
        b_next.sxsysz = mul30(a_reg.sxsy, a_reg.sz);
        b_next.cxsycz = mul30(a_reg.cxsy, a_reg.cz);
        b_next.cxsysz = mul30(a_reg.cxsy, a_reg.sz);
        b_next.cycz   = a_reg.cycz;
        b_next.cysz   = a_reg.cysz;
        b_next.cxsz   = a_reg.cxsz;
        b_next.cxcz   = a_reg.cxcz;
        b_next.sxcy   = a_reg.sxcy;
        b_next.sxsz   = a_reg.sxsz;
        b_next.sxcz   = a_reg.sxcz;
        b_next.cxcy   = a_reg.cxcy;
        b_next.sy     = a_reg.sy;
        b_next.trans  = a_reg.trans;
    end

    always_comb begin
        o_next.r00          = to_q14(ext(b_reg.cycz));
        o_next.r01          = to_q14(-ext(b_reg.cysz));
        o_next.r02          = to_q14(ext(b_reg.sy));
        o_next.r10          = to_q14(ext(b_reg.sxsycz) + ext(b_reg.cxsz));
        o_next.r11          = to_q14(ext(b_reg.cxcz) - ext(b_reg.sxsysz));
        o_next.r12          = to_q14(-ext(b_reg.sxcy));
        o_next.r20          = to_q14(ext(b_reg.sxsz) - ext(b_reg.cxsycz));
        o_next.r21          = to_q14(ext(b_reg.cxsysz) + ext(b_reg.sxcz));
        o_next.r22          = to_q14(ext(b_reg.cxcy));
        o_next.pass_trans_x = b_reg.trans.x;
        o_next.pass_trans_y = b_reg.trans.y;
        o_next.pass_trans_z = b_reg.trans.z;
    end

    assign o_ready  = !o_valid_reg || m_ready;
    assign b_ready  = !b_valid_reg || o_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (o_ready) begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_reg <= a_next;
        end
        if (a_valid_reg && b_ready) begin
            b_reg <= b_next;
        end
        if (b_valid_reg && o_ready) begin
            o_reg <= o_next;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_reg;

endmodule
`default_nettype wire

>>> hdl/euler_xyz_to_rotation_matrix.sv
// Top level: Euler XYZ angles plus translation in, rotation matrix plus translation out.
//
// Each input beat carries three Q2.13 angles and a Q16.16 translation; each output beat
// carries R = Rx*Ry*Rz as nine saturated Q1.14 entries and the translation unchanged.
// The block takes one pose per cycle while the output is not stalled and holds many
// in flight. Its stages are the angle clamp and fold, one cell per step of the CORDIC row
// (16 by default, at most 24 are used), two multiplier stages and the sum, rounding and
// output register. Every stage has its own valid bit, so stages behind a waiting output
// beat keep filling and the block accepts a new beat whenever any stage ahead of it can
// move.
`default_nettype none
module euler_xyz_to_rotation_matrix (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire exr_pkg::exr_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output exr_pkg::exr_out_t     m_data
);
    import exr_pkg::*;

    logic        chain_valid [STAGE_CNT+1];
    logic        chain_ready [STAGE_CNT+1];
    exr_cordic_t chain_data  [STAGE_CNT+1];

    exr_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar g = 0; g < STAGE_CNT; g++) begin : g_cell
        exr_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (SHIFT_W'(g)),
            .atan      (exr_atan(g)),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    exr_matrix u_matrix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[STAGE_CNT]),
        .in_ready (chain_ready[STAGE_CNT]),
        .in_data  (chain_data[STAGE_CNT]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

>>> hdl/exr_checker.sv
// Port-level checker for the Euler angle to rotation matrix block, with its bind.
`default_nettype none
`include "euler_xyz_to_rotation_matrix_defines.svh"
module exr_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire exr_pkg::exr_in_t  s_data,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire exr_pkg::exr_out_t m_data
);
    import exr_pkg::*;

    logic in_beat;

    assign in_beat = s_valid && s_ready;

    `EXR_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "output beat dropped while stalled")
    `EXR_ASSERT(a_out_stable, m_valid && !m_ready |=> $stable(m_data), "output beat changed while stalled")
    `EXR_ASSERT(a_ready_when_free, (!m_valid || m_ready) |-> s_ready, "input stalled with free output")
    `EXR_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "output valid right after reset")
    `EXR_ASSERT(a_first_out, $past(!aresetn) && !in_beat |=> !m_valid, "output beat without input")

endmodule

bind euler_xyz_to_rotation_matrix exr_checker u_exr_checker (.*);
`default_nettype wire
